// File: hdl/lmn_pkg.sv
// lmn_pkg: shared constants and register codes for the local min/max normalizer
// no dependencies
`default_nettype none

package lmn_pkg;

    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_MAX_LINE   = 128;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam int RADIUS_BITS = 6;
    localparam int WIN_BITS    = 5;
    localparam int RANGE_BITS  = 16;

    localparam int RADIUS_LIMIT = 56;
    localparam int WIN_LIMIT    = 16;

    localparam int RST_RADIUS    = 4;
    localparam int RST_WINDOW    = 3;
    localparam int RST_MIN_RANGE = 1;

    // unsigned q1.16 result
    localparam int FRAC_BITS = 16;
    localparam int NORM_BITS = FRAC_BITS + 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RADIUS    = 2'd0,
        REG_WINDOW    = 2'd1,
        REG_MIN_RANGE = 2'd2
    } t_cfg_reg;

endpackage

`default_nettype wire

// File: hdl/lmn_if.sv
// lmn_if: valid/ready channel interfaces for pixels, results and register writes
// depends on lmn_pkg
`default_nettype none

interface lmn_pix_if
    import lmn_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         pixel_valid;

    modport source (output valid, pixel_value, pixel_valid, input ready);
    modport sink   (input valid, pixel_value, pixel_valid, output ready);
endinterface

interface lmn_res_if
    import lmn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [NORM_BITS-1:0] norm_value;
    logic                 value_valid;
    logic                 last_result;

    modport source (output valid, norm_value, value_valid, last_result, input ready);
    modport sink   (input valid, norm_value, value_valid, last_result, output ready);
endinterface

interface lmn_cfg_if
    import lmn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/lmn_merge.sv
// lmn_merge: shared min/max compare unit folding one sample range into the accumulator
// depends on lmn_pkg
`default_nettype none

module lmn_merge
    import lmn_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  wire logic                         i_acc_ok,
    input  wire logic signed [PIXEL_BITS-1:0] i_acc_lo,
    input  wire logic signed [PIXEL_BITS-1:0] i_acc_hi,
    input  wire logic                         i_smp_ok,
    input  wire logic signed [PIXEL_BITS-1:0] i_smp_lo,
    input  wire logic signed [PIXEL_BITS-1:0] i_smp_hi,
    output logic                              o_ok,
    output logic signed [PIXEL_BITS-1:0]      o_lo,
    output logic signed [PIXEL_BITS-1:0]      o_hi
);

    always_comb begin
        if (!i_smp_ok) begin
            o_ok = i_acc_ok;
            o_lo = i_acc_lo;
            o_hi = i_acc_hi;
        end else if (!i_acc_ok) begin
            o_ok = 1'b1;
            o_lo = i_smp_lo;
            o_hi = i_smp_hi;
        end else begin
            o_ok = 1'b1;
            o_lo = (i_smp_lo < i_acc_lo) ? i_smp_lo : i_acc_lo;
            o_hi = (i_smp_hi > i_acc_hi) ? i_smp_hi : i_acc_hi;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lmn_div.sv
// lmn_div: restoring divider, one quotient bit per cycle, numerator not above denominator
// depends on lmn_pkg
`default_nettype none

module lmn_div
    import lmn_pkg::*;
#(
    parameter int DW = DEF_PIXEL_BITS + 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DW-1:0]        i_num,
    input  wire logic [DW-1:0]        i_den,
    output logic                      o_done,
    output logic [NORM_BITS-1:0]      o_quot
);

    localparam int CNTW = $clog2(NORM_BITS + 1);

    logic [CNTW-1:0]      r_cnt;
    logic                 r_first;
    logic                 r_done;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_den;
    logic [NORM_BITS-1:0] r_q;
    logic [DW:0]          t;
    logic [DW:0]          diff;
    logic                 ge;

    always_comb begin
        // first step compares the numerator itself for the integer bit
        t    = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        ge   = (t >= {1'b0, r_den});
        diff = t - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem   <= i_num;
                r_den   <= i_den;
                r_cnt   <= CNTW'(NORM_BITS);
                r_first <= 1'b1;
            end else if (r_cnt != '0) begin
                r_rem   <= ge ? diff[DW-1:0] : t[DW-1:0];
                r_q     <= {r_q[NORM_BITS-2:0], ge};
                r_first <= 1'b0;
                r_cnt   <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: hdl/local_minmax_normalize_core.sv
// sequence: a pixel that completes a window passes the column scan (window 2 and up), store,
// window scan and divide states before its result is registered; one forced to zero skips the divider;
// other pixels free the input after the column scan and store, or after the store alone before the column fills.
// one pixel at a time; a stalled result holds the next result, and so the input, until it transfers.
// reset: synchronous active-low; clears sequencer, position counters and registers to
// radius 4, window 3, min_range 1. line store and column extrema need no clearing.
`default_nettype none

module local_minmax_normalize_core
    import lmn_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_LINE   = DEF_MAX_LINE,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lmn_pix_if.sink    i_pix,
    lmn_cfg_if.sink    i_cfg,
    lmn_res_if.source  o_res
);

    localparam int PB   = PIXEL_BITS;
    localparam int DW   = PB + 1;
    localparam int CW   = $clog2(MAX_LINE);
    localparam int PW   = $clog2(MAX_LINE + 1);
    localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int WCAP = (MAX_WINDOW < MAX_LINE) ? MAX_WINDOW : MAX_LINE;
    localparam int CMPW = (DW > RANGE_BITS) ? DW : RANGE_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_COL, S_CLAST, S_STORE, S_WIN, S_DIV, S_DWAIT, S_OUT
    } t_state;

    t_state                r_state;
    logic [RADIUS_BITS-1:0] r_radius;
    logic [WIN_BITS-1:0]    r_window;
    logic [RANGE_BITS-1:0]  r_min_range;

    logic [PW-1:0] r_row, r_col;
    logic [SW-1:0] r_slot, r_cptr;

    logic [PW-1:0]          r_irow, r_icol;
    logic [SW-1:0]          r_islot, r_icptr, r_rptr;
    logic signed [PB-1:0]   r_ival;
    logic                   r_iok, r_ilast;
    logic [WW-1:0]          r_k;
    logic                   r_pend;

    logic                   r_aok;
    logic signed [PB-1:0]   r_lo, r_hi;
    logic signed [PB-1:0]   r_cv;
    logic                   r_cok;

    logic                   r_ov, r_out_vv, r_out_last;
    logic [NORM_BITS-1:0]   r_out_norm;
    logic [NORM_BITS-1:0]   r_norm;

    logic [PB:0]            r_line [MAX_WINDOW][MAX_LINE];
    logic [PB:0]            r_rdata;
    logic                   r_cx_ok [MAX_WINDOW];
    logic signed [PB-1:0]   r_cx_lo [MAX_WINDOW];
    logic signed [PB-1:0]   r_cx_hi [MAX_WINDOW];

    logic [WW-1:0] w_eff, wm1, dcen;
    logic [PW-1:0] p_side;
    logic          in_fire;
    logic          in_range;
    logic [PW-1:0] cur_row, cur_col;
    logic [SW-1:0] cur_slot, cur_cptr;
    logic          cur_colfull;
    logic          i_colfull, i_winfull;
    logic [SW-1:0] rd_slot, cen_slot;
    logic [CW-1:0] rd_col;
    logic          m_en, m_sok, m_ok;
    logic signed [PB-1:0] m_slo, m_shi, m_lo, m_hi;
    logic [DW-1:0] mag, num;
    logic          div_start, div_done;
    logic [NORM_BITS-1:0] div_q;
    logic          wr_line;
    logic          wr_cx;

    // effective window, radius and patch side
    always_comb begin
        int w_i, lim_i, r_i;
        w_i   = (int'(r_window) > WCAP) ? WCAP : int'(r_window);
        lim_i = (MAX_LINE - w_i) / 2;
        r_i   = (int'(r_radius) > lim_i) ? lim_i : int'(r_radius);
        w_eff  = WW'(w_i);
        wm1    = WW'(w_i - 1);
        dcen   = WW'(w_i - 1 - w_i / 2);
        p_side = PW'(2 * r_i + w_i);
    end

    assign in_fire  = i_pix.valid && i_pix.ready;
    assign in_range = (r_row < p_side) && (r_col < p_side);

    always_comb begin
        cur_row  = in_range ? r_row  : '0;
        cur_col  = in_range ? r_col  : '0;
        cur_slot = in_range ? r_slot : '0;
        cur_cptr = in_range ? r_cptr : '0;
        cur_colfull = (int'(cur_row) + 1 >= int'(w_eff));
        i_colfull   = (int'(r_irow) + 1 >= int'(w_eff));
        i_winfull   = i_colfull && (int'(r_icol) + 1 >= int'(w_eff));
    end

    // centre sits dcen rows up in the row ring and dcen columns left
    always_comb begin
        int s_i;
        s_i = int'(r_islot) - int'(dcen);
        if (s_i < 0) begin
            s_i = s_i + int'(wm1);
        end
        cen_slot = SW'(s_i);
        if (r_state == S_WIN) begin
            rd_slot = cen_slot;
            rd_col  = CW'(r_icol - PW'(dcen));
        end else begin
            rd_slot = r_k[SW-1:0];
            rd_col  = r_icol[CW-1:0];
        end
    end

    // compare unit input: stored column pixels, then column extrema
    always_comb begin
        m_en  = 1'b0;
        m_sok = 1'b0;
        m_slo = r_rdata[PB-1:0];
        m_shi = r_rdata[PB-1:0];
        unique case (r_state)
            S_COL, S_CLAST: begin
                m_en  = r_pend;
                m_sok = r_rdata[PB];
            end
            S_WIN: begin
                m_en  = 1'b1;
                m_sok = r_cx_ok[r_rptr];
                m_slo = r_cx_lo[r_rptr];
                m_shi = r_cx_hi[r_rptr];
            end
            default: begin
                m_en = 1'b0;
            end
        endcase
    end

    lmn_merge #(.PIXEL_BITS(PB)) u_lmn_merge (
        .i_acc_ok (r_aok),
        .i_acc_lo (r_lo),
        .i_acc_hi (r_hi),
        .i_smp_ok (m_sok),
        .i_smp_lo (m_slo),
        .i_smp_hi (m_shi),
        .o_ok     (m_ok),
        .o_lo     (m_lo),
        .o_hi     (m_hi)
    );

    always_comb begin
        logic signed [DW-1:0] hi_x, lo_x, cv_x;
        hi_x = DW'(r_hi);
        lo_x = DW'(r_lo);
        cv_x = DW'(r_cv);
        mag  = hi_x - lo_x;
        num  = cv_x - lo_x;
        div_start = (r_state == S_DIV) && r_cok && r_aok && (mag != '0) &&
                    (CMPW'(mag) >= CMPW'(r_min_range));
    end

    lmn_div #(.DW(DW)) u_lmn_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (mag),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign wr_line = (r_state == S_STORE) && (w_eff >= WW'(2));
    assign wr_cx   = (r_state == S_STORE) && i_colfull;

    always_ff @(posedge i_clk) begin
        if (wr_line) begin
            r_line[r_islot][r_icol[CW-1:0]] <= {r_iok, r_ival};
        end
        r_rdata <= r_line[rd_slot][rd_col];
    end

    always_ff @(posedge i_clk) begin
        if (wr_cx) begin
            r_cx_ok[r_icptr] <= r_aok;
            r_cx_lo[r_icptr] <= r_lo;
            r_cx_hi[r_icptr] <= r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= RADIUS_BITS'(RST_RADIUS);
            r_window    <= WIN_BITS'(RST_WINDOW);
            r_min_range <= RANGE_BITS'(RST_MIN_RANGE);
            r_row       <= '0;
            r_col       <= '0;
            r_slot      <= '0;
            r_cptr      <= '0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_RADIUS) begin
                    r_radius <= (int'(i_cfg.data) > RADIUS_LIMIT) ?
                                RADIUS_BITS'(RADIUS_LIMIT) : i_cfg.data[RADIUS_BITS-1:0];
                end else if (i_cfg.index == REG_WINDOW) begin
                    if (i_cfg.data == '0) begin
                        r_window <= WIN_BITS'(1);
                    end else if (int'(i_cfg.data) > WIN_LIMIT) begin
                        r_window <= WIN_BITS'(WIN_LIMIT);
                    end else begin
                        r_window <= i_cfg.data[WIN_BITS-1:0];
                    end
                end else if (i_cfg.index == REG_MIN_RANGE) begin
                    r_min_range <= i_cfg.data[RANGE_BITS-1:0];
                end
                if (i_cfg.index == REG_RADIUS || i_cfg.index == REG_WINDOW ||
                    i_cfg.index == REG_MIN_RANGE) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_slot <= '0;
                    r_cptr <= '0;
                end
            end

            // in S_OUT the output register is reloaded instead
            if (o_res.valid && o_res.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end

            if (m_en) begin
                r_aok <= m_ok;
                r_lo  <= m_lo;
                r_hi  <= m_hi;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_irow  <= cur_row;
                        r_icol  <= cur_col;
                        r_islot <= cur_slot;
                        r_icptr <= cur_cptr;
                        r_ival  <= i_pix.pixel_value;
                        r_iok   <= i_pix.pixel_valid;
                        r_ilast <= (cur_row == p_side - PW'(1)) &&
                                   (cur_col == p_side - PW'(1));
                        r_aok   <= i_pix.pixel_valid;
                        r_lo    <= i_pix.pixel_value;
                        r_hi    <= i_pix.pixel_value;
                        r_k     <= '0;
                        r_pend  <= 1'b0;
                        // advance the patch position
                        if (int'(cur_col) + 1 >= int'(p_side)) begin
                            r_col  <= '0;
                            r_cptr <= '0;
                            if (int'(cur_row) + 1 >= int'(p_side)) begin
                                r_row  <= '0;
                                r_slot <= '0;
                            end else begin
                                r_row  <= cur_row + PW'(1);
                                r_slot <= (int'(cur_slot) + 1 >= int'(wm1)) ?
                                          '0 : cur_slot + SW'(1);
                            end
                        end else begin
                            r_row  <= cur_row;
                            r_col  <= cur_col + PW'(1);
                            r_slot <= cur_slot;
                            r_cptr <= (int'(cur_cptr) == MAX_WINDOW - 1) ?
                                      '0 : cur_cptr + SW'(1);
                        end
                        if (cur_colfull && w_eff >= WW'(2)) begin
                            r_state <= S_COL;
                        end else begin
                            r_state <= S_STORE;
                        end
                    end
                end
                S_COL: begin
                    r_pend <= 1'b1;
                    r_k    <= r_k + WW'(1);
                    if (r_k == wm1 - WW'(1)) begin
                        r_state <= S_CLAST;
                    end
                end
                S_CLAST: begin
                    r_pend  <= 1'b0;
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    r_cv  <= r_ival;
                    r_cok <= r_iok;
                    if (i_winfull) begin
                        r_aok   <= 1'b0;
                        r_k     <= '0;
                        r_rptr  <= r_icptr;
                        r_state <= S_WIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_WIN: begin
                    r_rptr <= (r_rptr == '0) ? SW'(MAX_WINDOW - 1) : r_rptr - SW'(1);
                    r_k    <= r_k + WW'(1);
                    if (r_k == WW'(1)) begin
                        r_cv  <= r_rdata[PB-1:0];
                        r_cok <= r_rdata[PB];
                    end
                    if (r_k == wm1) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_start) begin
                        r_state <= S_DWAIT;
                    end else begin
                        r_norm  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_norm  <= div_q;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov       <= 1'b1;
                        r_out_norm <= r_norm;
                        r_out_vv   <= r_cok;
                        r_out_last <= r_ilast;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_pix.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_ov;
    assign o_res.norm_value  = r_out_norm;
    assign o_res.value_valid = r_out_vv;
    assign o_res.last_result = r_out_last;

endmodule

`default_nettype wire

// File: hdl/lmn_checker.sv
// lmn_checker: port-level assertions for the normalizer, bound to the top level
// depends on lmn_pkg and local_minmax_normalize_core
`default_nettype none

module lmn_checker
    import lmn_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [NORM_BITS-1:0] i_norm_value,
    input wire logic                 i_value_valid
);

    // one pixel at a time: the input closes after every transfer
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still open after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_value_valid |-> i_norm_value == '0)
        else $error("missing centre with nonzero value");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_norm_value <= NORM_BITS'(1 << FRAC_BITS))
        else $error("normalized value above one");

endmodule

bind local_minmax_normalize_core lmn_checker u_lmn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_norm_value  (o_res.norm_value),
    .i_value_valid (o_res.value_valid)
);

`default_nettype wire

// File: test/tb_top.sv
// tb_top: self-checking bench for local_minmax_normalize_core, streaming patches under
// random source gaps and sink stalls and checking each result against an internal model
// depends on lmn_pkg, lmn_if and the core
`timescale 1ns / 100ps

module tb_top;
    import lmn_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic signed [15:0] value;
        logic               ok;
    } pixel_t;

    typedef struct {
        logic [NORM_BITS-1:0] norm;
        logic                 ok;
        logic                 last;
    } norm_t;

    typedef struct {
        int lo;
        int hi;
        bit ok;
    } span_t;

    logic i_clk;
    logic i_rst_n;

    lmn_pix_if pix ();
    lmn_cfg_if cfg ();
    lmn_res_if res ();

    local_minmax_normalize_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // model state
    logic signed [15:0] row_val [DEF_MAX_WINDOW][DEF_MAX_LINE];
    bit                 row_ok  [DEF_MAX_WINDOW][DEF_MAX_LINE];
    span_t              col_span [DEF_MAX_WINDOW];
    int                 cur_row, cur_col;
    int                 cfg_radius, cfg_window, cfg_min_range;

    pixel_t pixel_q[$];
    norm_t  norm_q[$];
    pixel_t offered;
    int     n_pushed, n_accepted, n_results, n_errors;
    int     gap_cnt, burst_cnt;
    int     hold_cnt, stall_mode, mode_cnt;
    bit     held;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic span_t span_merge(span_t e, int v, bit ok);
        if (!ok) return e;
        if (!e.ok) begin
            e.lo = v;
            e.hi = v;
            e.ok = 1'b1;
        end else begin
            if (v < e.lo) e.lo = v;
            if (v > e.hi) e.hi = v;
        end
        return e;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] d);
        case (idx)
            REG_RADIUS:    cfg_radius    = (d > RADIUS_LIMIT) ? RADIUS_LIMIT : d;
            REG_WINDOW:    cfg_window    = (d < 1) ? 1 : (d > WIN_LIMIT) ? WIN_LIMIT : d;
            REG_MIN_RANGE: cfg_min_range = d;
            default:       return;
        endcase
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic int patch_side();
        int lim, r;
        lim = (DEF_MAX_LINE - cfg_window) / 2;
        r = (cfg_radius > lim) ? lim : cfg_radius;
        return 2 * r + cfg_window;
    endfunction

    // advance the patch position by one pixel and queue the result it completes
    function automatic void normalize_pixel(pixel_t p);
        int ws, half, side, row, col, k, d, cv;
        bit cok;
        span_t e;
        norm_t r;
        longint mag, num, q;
        ws = cfg_window;
        half = ws / 2;
        side = patch_side();
        row = cur_row;
        col = cur_col;
        if (row >= side || col >= side) begin
            row = 0;
            col = 0;
        end
        if (row + 1 >= ws) begin
            e = '{0, 0, 1'b0};
            e = span_merge(e, p.value, p.ok);
            for (k = 1; k < ws; k++)
                e = span_merge(e, row_val[(row - k) % (ws - 1)][col],
                               row_ok[(row - k) % (ws - 1)][col]);
            col_span[col % DEF_MAX_WINDOW] = e;
        end
        if (ws >= 2) begin
            row_val[row % (ws - 1)][col] = p.value;
            row_ok[row % (ws - 1)][col]  = p.ok;
        end
        if (row + 1 >= ws && col + 1 >= ws) begin
            d = ws - 1 - half;
            e = '{0, 0, 1'b0};
            for (k = 0; k < ws; k++) begin
                if (col_span[(col - k) % DEF_MAX_WINDOW].ok) begin
                    e = span_merge(e, col_span[(col - k) % DEF_MAX_WINDOW].lo, 1'b1);
                    e = span_merge(e, col_span[(col - k) % DEF_MAX_WINDOW].hi, 1'b1);
                end
            end
            if (ws == 1) begin
                cv  = p.value;
                cok = p.ok;
            end else begin
                cv  = row_val[(row - d) % (ws - 1)][col - d];
                cok = row_ok[(row - d) % (ws - 1)][col - d];
            end
            q = 0;
            if (cok && e.ok) begin
                mag = e.hi - e.lo;
                if (mag != 0 && mag >= cfg_min_range) begin
                    num = longint'(cv - e.lo) <<< 16;
                    q = num / mag;
                    if (q > 65536) q = 65536;
                end
            end
            r.norm = q[NORM_BITS-1:0];
            r.ok   = cok;
            r.last = (row == side - 1 && col == side - 1);
            norm_q.push_back(r);
        end
        col++;
        if (col >= side) begin
            col = 0;
            row++;
            if (row >= side) row = 0;
        end
        cur_row = row;
        cur_col = col;
    endfunction

    // pixel source: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            gap_cnt   <= 0;
            burst_cnt <= 8;
        end else begin
            if (pix.valid && pix.ready) begin
                normalize_pixel(offered);
                n_accepted++;
            end
            if (pix.valid && !pix.ready) begin
                pix.valid <= 1'b1;
            end else if (gap_cnt > 0) begin
                gap_cnt--;
                pix.valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                offered = pixel_q.pop_front();
                pix.pixel_value <= offered.value;
                pix.pixel_valid <= offered.ok;
                pix.valid       <= 1'b1;
                burst_cnt--;
                if (burst_cnt <= 0) begin
                    burst_cnt = $urandom_range(1, 40);
                    gap_cnt   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                pix.valid <= 1'b0;
            end
        end
    end

    // result sink: checks each transfer, stalls according to a stall mode that is redrawn at random
    always @(posedge i_clk) begin
        norm_t x;
        if (!i_rst_n) begin
            res.ready  <= 1'b0;
            hold_cnt   <= 0;
            held       <= 1'b0;
            stall_mode <= 0;
            mode_cnt   <= 0;
        end else begin
            if (res.valid && res.ready) begin
                n_results++;
                if (norm_q.size() == 0) begin
                    $error("unexpected result norm_value %0d", res.norm_value);
                    n_errors++;
                end else begin
                    x = norm_q.pop_front();
                    if (res.norm_value !== x.norm) begin
                        $error("norm_value expected %0d actual %0d", x.norm, res.norm_value);
                        n_errors++;
                    end
                    if (res.value_valid !== x.ok) begin
                        $error("value_valid expected %0d actual %0d", x.ok, res.value_valid);
                        n_errors++;
                    end
                    if (res.last_result !== x.last) begin
                        $error("last_result expected %0d actual %0d", x.last, res.last_result);
                        n_errors++;
                    end
                end
            end
            mode_cnt++;
            if (mode_cnt >= 64) begin
                mode_cnt = 0;
                stall_mode = $urandom_range(0, 2);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                res.ready <= 1'b0;
            end else if (!held && n_results >= 40) begin
                // long back-pressure so the core fills and stalls its pixel input
                held = 1'b1;
                hold_cnt = 3000;
                res.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= ($urandom_range(0, 3) != 0);
                    default: res.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do @(posedge i_clk); while (!cfg.ready);
        apply_reg(idx, d);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || n_accepted != n_pushed || norm_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_pixel(int v, bit ok);
        pixel_t p;
        p.value = v;
        p.ok    = ok;
        pixel_q.push_back(p);
        n_pushed++;
    endtask

    // content styles: 0 full range, 1 narrow band, 2 flat, 3 mostly missing
    task automatic push_random(int n, int style);
        int base, miss_pct, i;
        base = $urandom_range(0, 65535) - 32768;
        miss_pct = (style == 3) ? 85 : $urandom_range(0, 25);
        for (i = 0; i < n; i++) begin
            case (style)
                1:       push_pixel(((base + $urandom_range(0, 40)) & 16'hFFFF) << 16 >>> 16,
                                    $urandom_range(0, 99) >= miss_pct);
                2:       push_pixel(base, $urandom_range(0, 99) >= miss_pct);
                default: push_pixel($urandom_range(0, 65535) - 32768,
                                    $urandom_range(0, 99) >= miss_pct);
            endcase
        end
    endtask

    task automatic run_phase(int r, int w, int mr, int n, int style);
        write_reg(REG_RADIUS, r);
        write_reg(REG_WINDOW, w);
        write_reg(REG_MIN_RANGE, mr);
        push_random(n, style);
        drain();
    endtask

    initial begin
        int side;
        pix.valid       = 1'b0;
        pix.pixel_value = '0;
        pix.pixel_valid = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_RADIUS;
        cfg.data        = '0;
        res.ready       = 1'b0;
        n_pushed = 0;
        n_accepted = 0;
        n_results = 0;
        n_errors = 0;
        cur_row = 0;
        cur_col = 0;
        cfg_radius = RST_RADIUS;
        cfg_window = RST_WINDOW;
        cfg_min_range = RST_MIN_RANGE;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes, missing centres, flat and tiny ranges
        push_pixel(-32768, 1); push_pixel(32767, 1);  push_pixel(0, 1);
        push_pixel(-1, 1);     push_pixel(1, 0);      push_pixel(32767, 0);
        push_pixel(-32768, 0); push_pixel(5, 1);      push_pixel(5, 1);
        push_pixel(5, 1);      push_pixel(6, 1);      push_pixel(-32768, 1);
        push_pixel(32767, 1);  push_pixel(0, 0);      push_pixel(0, 0);
        push_pixel(0, 0);      push_pixel(7, 1);      push_pixel(7, 1);
        push_pixel(7, 1);      push_pixel(-2, 1);     push_pixel(32767, 1);
        push_pixel(-32768, 1); push_pixel(100, 0);    push_pixel(-100, 1);
        push_pixel(0, 1);
        push_random(96, 0);
        drain();

        run_phase(16'hFFFF, 0, 0, 200, 0);          // radius clamps to 56, window to 1
        run_phase(0, 16'hFFFF, 16'hFFFF, 256, 0);   // single result per patch
        run_phase(0, 1, 0, 30, 3);
        run_phase(1, 31, 0, 324, 1);
        write_reg(REG_UNUSED, 16'h5A5A);
        push_random(60, 0);
        drain();

        while (n_pushed < 1250) begin
            write_reg(REG_RADIUS, $urandom_range(0, 3));
            write_reg(REG_WINDOW, $urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_MIN_RANGE, 0);
                1:       write_reg(REG_MIN_RANGE, 1);
                2:       write_reg(REG_MIN_RANGE, $urandom_range(2, 60));
                default: write_reg(REG_MIN_RANGE, $urandom_range(0, 65535));
            endcase
            side = patch_side();
            push_random(side * side * $urandom_range(1, 2), $urandom_range(0, 3));
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && norm_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
